// ===== rtl/brd_pkg.sv =====
// Shared types and constants of the response deframer.
package brd_pkg;

   // Frame delimiters and command codes.
   localparam logic [7:0] START_BYTE   = 8'hDD;
   localparam logic [7:0] END_BYTE     = 8'h77;
   localparam logic [7:0] CMD_HWINFO   = 8'h03;
   localparam logic [7:0] CMD_CELLINFO = 8'h04;
   localparam logic [7:0] STATUS_OK    = 8'h00;

   // A frame is the payload plus start, command, status, length, two checksum
   // bytes and the end byte.
   localparam int unsigned FRAME_OVERHEAD = 7;
   localparam int unsigned LEN_OFFSET     = 3;
   localparam int unsigned MIN_HEADER     = 4;
   localparam int unsigned FLEN_W         = 9;

   // Shortest hardware-info payload decoded for voltage, current and charge.
   localparam logic [7:0] MIN_INFO_PAYLOAD = 8'd23;

   // Frames taken out of the store per received byte, at most.
   localparam int unsigned RES_W       = 6;
   localparam logic [RES_W-1:0] MAX_RESULTS = 6'd37;

   // Header and payload bytes fetched for each accepted frame, as offsets
   // from the start byte: command, status, voltage high/low, current
   // high/low and charge.
   localparam int unsigned HDR_READS = 7;
   localparam int unsigned HDR_IDX_W = 3;
   localparam logic [4:0] HDR_OFFSET [HDR_READS] = '{
      5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd7, 5'd23
   };
   localparam logic [HDR_IDX_W-1:0] HDR_CMD    = 3'd0;
   localparam logic [HDR_IDX_W-1:0] HDR_STATUS = 3'd1;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST   = 3'd6;

   // Kind of frame reported in a result word.
   typedef enum logic [2:0] {
      KIND_INFO       = 3'd0,
      KIND_INFO_SHORT = 3'd1,
      KIND_CELL       = 3'd2,
      KIND_OTHER      = 3'd3,
      KIND_ERROR      = 3'd4
   } frame_kind_type;

   // One result word.
   typedef struct packed {
      frame_kind_type     frame_kind;
      logic [7:0]         command_code;
      logic [7:0]         status_byte;
      logic [7:0]         payload_length;
      logic [15:0]        pack_voltage;
      logic signed [15:0] pack_current;
      logic [7:0]         charge_percent;
      logic               voltage_changed;
      logic               current_changed;
      logic               charge_changed;
      logic               any_changed;
      logic               last_of_run;
   } rsp_word_type;

endpackage

// ===== rtl/brd_channels.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface brd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface brd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         frame_kind;
   logic [7:0]         command_code;
   logic [7:0]         status_byte;
   logic [7:0]         payload_length;
   logic [15:0]        pack_voltage;
   logic signed [15:0] pack_current;
   logic [7:0]         charge_percent;
   logic               voltage_changed;
   logic               current_changed;
   logic               charge_changed;
   logic               any_changed;
   logic               last_of_run;

   modport source (
      output valid, output frame_kind, output command_code, output status_byte,
      output payload_length, output pack_voltage, output pack_current,
      output charge_percent, output voltage_changed, output current_changed,
      output charge_changed, output any_changed, output last_of_run,
      input ready
   );
   modport sink (
      input valid, input frame_kind, input command_code, input status_byte,
      input payload_length, input pack_voltage, input pack_current,
      input charge_percent, input voltage_changed, input current_changed,
      input charge_changed, input any_changed, input last_of_run,
      output ready
   );
endinterface

// ===== rtl/brd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bms_response_deframer.sv =====
// Response deframer: rebuilds framed battery-monitor responses from a byte stream.
//
// Bytes enter on req_in, one word per byte, and are appended to a circular
// frame store in a RAM. After each byte the store is scanned for complete
// frames (start byte, command, status, length, payload, two checksum bytes,
// end byte). Each frame found yields one word on rsp_out, carrying its kind,
// header bytes and the held voltage, current and charge; last_of_run marks
// the final word caused by one byte. The checksum is not checked.
// Flow: a new byte is taken only once the previous byte's processing is
// over. Each byte is appended in S_IDLE and checked in S_CHECK; when at
// least 7 bytes are held, the store is scanned for a start byte, the
// candidate's length and end byte are read, and each frame found has its
// header bytes fetched before S_DECIDE; S_FLUSH ends the byte. Every store
// access is one RAM read state followed by an evaluate state.
// Result words wait in an output register plus one held word; with a word
// held, a stalled rsp_out stops the scan at the next frame or end; no byte enters.
// Reset empties the store and clears the held values; the RAM is not cleared.
module bms_response_deframer #(
   parameter int STORE_DEPTH = 512
) (
   input logic     clock,
   input logic     reset,
   brd_req_if.sink req_in,
   brd_rsp_if.source rsp_out
);

   import brd_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int SW = CW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_EV, S_LEN_RD, S_LEN_EV,
      S_END_RD, S_END_EV, S_HDR_RD, S_HDR_EV, S_DECIDE, S_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        off_ff, off_in;
   logic [CW-1:0]        flen_ff, flen_in;
   logic [7:0]           len_ff, len_in;
   logic [RES_W-1:0]     nres_ff, nres_in;
   logic [HDR_IDX_W-1:0] fld_ff, fld_in;
   logic [7:0]           hdr_ff [HDR_READS];
   logic [7:0]           hdr_in [HDR_READS];
   logic [15:0]          held_voltage_ff, held_voltage_in;
   logic [15:0]          held_current_ff, held_current_in;
   logic [7:0]           held_charge_ff, held_charge_in;
   rsp_word_type         pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_word_type         out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [7:0]           ram_rd_data;

   logic                 move_ok;
   logic [CW-1:0]        scan_rest;
   logic [FLEN_W-1:0]    flen_full;
   logic [15:0]          new_voltage;
   logic [15:0]          new_current;
   logic [7:0]           new_charge;
   rsp_word_type         new_word;

   // Address of an offset from the head of the circular store.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] delta);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(delta);
      if (sum >= SW'(STORE_DEPTH)) begin
         sum = sum - SW'(STORE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   brd_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_in.rx_byte),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Decode of the frame whose header bytes have been fetched.
   always_comb begin
      new_voltage = {hdr_ff[2], hdr_ff[3]};
      new_current = {hdr_ff[4], hdr_ff[5]};
      new_charge  = hdr_ff[6];
      new_word = '0;
      new_word.command_code   = hdr_ff[HDR_CMD];
      new_word.status_byte    = hdr_ff[HDR_STATUS];
      new_word.payload_length = len_ff;
      new_word.pack_voltage   = held_voltage_ff;
      new_word.pack_current   = held_current_ff;
      new_word.charge_percent = held_charge_ff;
      priority if (hdr_ff[HDR_STATUS] != STATUS_OK) begin
         new_word.frame_kind = KIND_ERROR;
      end else if (hdr_ff[HDR_CMD] == CMD_HWINFO) begin
         if (len_ff < MIN_INFO_PAYLOAD) begin
            new_word.frame_kind = KIND_INFO_SHORT;
         end else begin
            new_word.frame_kind      = KIND_INFO;
            new_word.pack_voltage    = new_voltage;
            new_word.pack_current    = new_current;
            new_word.charge_percent  = new_charge;
            new_word.voltage_changed = (new_voltage != held_voltage_ff);
            new_word.current_changed = (new_current != held_current_ff);
            new_word.charge_changed  = (new_charge != held_charge_ff);
         end
      end else if (hdr_ff[HDR_CMD] == CMD_CELLINFO) begin
         new_word.frame_kind = KIND_CELL;
      end else begin
         new_word.frame_kind = KIND_OTHER;
      end
      new_word.any_changed = new_word.voltage_changed | new_word.current_changed
                             | new_word.charge_changed;
   end

   // Sequencer: append the byte, then scan, check and fetch frames.
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      off_in          = off_ff;
      flen_in         = flen_ff;
      len_in          = len_ff;
      nres_in         = nres_ff;
      fld_in          = fld_ff;
      hdr_in          = hdr_ff;
      held_voltage_in = held_voltage_ff;
      held_current_in = held_current_ff;
      held_charge_in  = held_charge_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      out_in          = out_ff;
      rsp_valid_in    = rsp_valid_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = wrap_add(head_ff, count_ff);
      ram_rd_en       = 1'b0;
      ram_rd_addr     = wrap_add(head_ff, off_ff);
      move_ok         = !rsp_valid_ff || rsp_out.ready;
      scan_rest       = count_ff - off_ff;
      flen_full       = FLEN_W'(ram_rd_data) + FLEN_W'(FRAME_OVERHEAD);

      if (rsp_valid_ff && rsp_out.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_in.valid) begin
               nres_in = '0;
               if (count_ff < CW'(STORE_DEPTH)) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (count_ff >= CW'(FRAME_OVERHEAD) && nres_ff < MAX_RESULTS) begin
               off_in   = '0;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_SCAN_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            // Drop everything before the first start byte.
            if (ram_rd_data == START_BYTE) begin
               head_in  = wrap_add(head_ff, off_ff);
               count_in = scan_rest;
               if (scan_rest < CW'(MIN_HEADER)) begin
                  state_in = S_FLUSH;
               end else begin
                  off_in   = CW'(LEN_OFFSET);
                  state_in = S_LEN_RD;
               end
            end else if (SW'(off_ff) + 1'b1 >= SW'(count_ff)) begin
               count_in = '0;
               state_in = S_FLUSH;
            end else begin
               off_in   = off_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_LEN_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_LEN_EV;
         end
         S_LEN_EV: begin
            len_in  = ram_rd_data;
            flen_in = CW'(flen_full);
            if (count_ff < CW'(flen_full)) begin
               state_in = S_FLUSH;
            end else begin
               off_in   = CW'(flen_full) - 1'b1;
               state_in = S_END_RD;
            end
         end
         S_END_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_END_EV;
         end
         S_END_EV: begin
            // A wrong end byte costs the candidate its start byte.
            if (ram_rd_data != END_BYTE) begin
               head_in  = wrap_add(head_ff, CW'(1));
               count_in = count_ff - 1'b1;
               state_in = S_CHECK;
            end else begin
               fld_in   = '0;
               off_in   = CW'(HDR_OFFSET[0]);
               state_in = S_HDR_RD;
            end
         end
         S_HDR_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_HDR_EV;
         end
         S_HDR_EV: begin
            hdr_in[fld_ff] = ram_rd_data;
            if (fld_ff == HDR_LAST) begin
               state_in = S_DECIDE;
            end else begin
               fld_in   = fld_ff + 1'b1;
               off_in   = CW'(HDR_OFFSET[fld_ff + 1'b1]);
               state_in = S_HDR_RD;
            end
         end
         S_DECIDE: begin
            // The held word goes out here, as not last, once a later frame is found.
            if (!pend_valid_ff || move_ok) begin
               if (pend_valid_ff) begin
                  out_in             = pend_ff;
                  out_in.last_of_run = 1'b0;
                  rsp_valid_in       = 1'b1;
               end
               pend_in         = new_word;
               pend_valid_in   = 1'b1;
               held_voltage_in = new_word.pack_voltage;
               held_current_in = new_word.pack_current;
               held_charge_in  = new_word.charge_percent;
               head_in         = wrap_add(head_ff, flen_ff);
               count_in        = count_ff - flen_ff;
               nres_in         = nres_ff + 1'b1;
               state_in        = S_CHECK;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (move_ok) begin
               out_in             = pend_ff;
               out_in.last_of_run = 1'b1;
               rsp_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         head_ff         <= '0;
         count_ff        <= '0;
         nres_ff         <= '0;
         fld_ff          <= '0;
         held_voltage_ff <= '0;
         held_current_ff <= '0;
         held_charge_ff  <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         nres_ff         <= nres_in;
         fld_ff          <= fld_in;
         held_voltage_ff <= held_voltage_in;
         held_current_ff <= held_current_in;
         held_charge_ff  <= held_charge_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      off_ff  <= off_in;
      flen_ff <= flen_in;
      len_ff  <= len_in;
      hdr_ff  <= hdr_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   // Channel ports.
   assign req_in.ready            = (state_ff == S_IDLE);
   assign rsp_out.valid           = rsp_valid_ff;
   assign rsp_out.frame_kind      = out_ff.frame_kind;
   assign rsp_out.command_code    = out_ff.command_code;
   assign rsp_out.status_byte     = out_ff.status_byte;
   assign rsp_out.payload_length  = out_ff.payload_length;
   assign rsp_out.pack_voltage    = out_ff.pack_voltage;
   assign rsp_out.pack_current    = out_ff.pack_current;
   assign rsp_out.charge_percent  = out_ff.charge_percent;
   assign rsp_out.voltage_changed = out_ff.voltage_changed;
   assign rsp_out.current_changed = out_ff.current_changed;
   assign rsp_out.charge_changed  = out_ff.charge_changed;
   assign rsp_out.any_changed     = out_ff.any_changed;
   assign rsp_out.last_of_run     = out_ff.last_of_run;

   // A new byte never arrives while a word of the previous run is still held.
   a_no_byte_with_pending: assert property (@(posedge clock) disable iff (reset)
      req_in.valid && req_in.ready |-> !pend_valid_ff)
      else $error("byte accepted while a result word is still held");

   // The fill count never exceeds the store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   // A frame is only taken out when all of its bytes are held.
   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> count_ff >= flen_ff)
      else $error("frame removed before it was complete");

   // No more than the allowed number of frames is taken per byte.
   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      nres_ff <= MAX_RESULTS)
      else $error("too many frames taken for one byte");

endmodule

// ===== bench/bms_response_deframer_tb.sv =====
// Self-checking testbench for the response deframer: byte stimulus, frame prediction, result check.
module bms_response_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brd_pkg::*;

   localparam int STORE_DEPTH   = 512;
   localparam int CHARGE_OFFSET = 23;
   localparam int RANDOM_BYTES  = 32;
   localparam int RANDOM_FRAMES = 2;
   localparam int WHOLE_FRAME   = 1000;
   localparam int SETTLE_CYCLES = 1200;
   localparam int PRINT_LIMIT   = 40;

   logic clock;
   logic reset;

   brd_req_if req_if();
   brd_rsp_if rsp_if();

   bms_response_deframer #(
      .STORE_DEPTH(STORE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_if.sink),
      .rsp_out(rsp_if.source)
   );

   // Mirrors the frame store and held values, and keeps the frame words still owed.
   class frame_scoreboard;
      logic [7:0]   held_bytes[$];
      logic [15:0]  held_voltage;
      logic [15:0]  held_current;
      logic [7:0]   held_charge;
      rsp_word_type owed_words[$];
      int           mismatches;
      int           bytes_seen;
      int           frames_owed_total;
      int           frames_checked;

      function new();
         held_voltage      = '0;
         held_current      = '0;
         held_charge       = '0;
         mismatches        = 0;
         bytes_seen        = 0;
         frames_owed_total = 0;
         frames_checked    = 0;
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function void drop_front(int n);
         for (int i = 0; i < n && held_bytes.size() > 0; i++)
            void'(held_bytes.pop_front());
      endfunction

      // Decodes the frame at the head of the store and updates the held values.
      function rsp_word_type decode_frame();
         rsp_word_type w;
         logic [15:0]  volt;
         logic [15:0]  curr;
         logic [7:0]   chg;
         w = '0;
         w.command_code   = held_bytes[1];
         w.status_byte    = held_bytes[2];
         w.payload_length = held_bytes[LEN_OFFSET];
         if (w.status_byte != STATUS_OK) begin
            w.frame_kind = KIND_ERROR;
         end else if (w.command_code == CMD_HWINFO) begin
            if (w.payload_length < MIN_INFO_PAYLOAD) begin
               w.frame_kind = KIND_INFO_SHORT;
            end else begin
               w.frame_kind = KIND_INFO;
               volt = {held_bytes[4], held_bytes[5]};
               curr = {held_bytes[6], held_bytes[7]};
               chg  = held_bytes[CHARGE_OFFSET];
               w.voltage_changed = (volt != held_voltage);
               w.current_changed = (curr != held_current);
               w.charge_changed  = (chg != held_charge);
               held_voltage = volt;
               held_current = curr;
               held_charge  = chg;
            end
         end else if (w.command_code == CMD_CELLINFO) begin
            w.frame_kind = KIND_CELL;
         end else begin
            w.frame_kind = KIND_OTHER;
         end
         w.any_changed    = w.voltage_changed | w.current_changed | w.charge_changed;
         w.pack_voltage   = held_voltage;
         w.pack_current   = held_current;
         w.charge_percent = held_charge;
         return w;
      endfunction

      // Appends one accepted byte and takes every frame it completes, up to MAX_RESULTS.
      function void note_byte(logic [7:0] rx);
         int           taken;
         int           start;
         int           flen;
         rsp_word_type w;
         bytes_seen++;
         if (held_bytes.size() < STORE_DEPTH)
            held_bytes.push_back(rx);
         taken = 0;
         while (held_bytes.size() >= FRAME_OVERHEAD && taken < MAX_RESULTS) begin
            start = 0;
            while (start < held_bytes.size() && held_bytes[start] != START_BYTE)
               start++;
            if (start >= held_bytes.size()) begin
               held_bytes.delete();
               break;
            end
            drop_front(start);
            if (held_bytes.size() < MIN_HEADER)
               break;
            flen = int'(held_bytes[LEN_OFFSET]) + FRAME_OVERHEAD;
            if (held_bytes.size() < flen)
               break;
            // A bad end byte costs the candidate its start byte only.
            if (held_bytes[flen-1] != END_BYTE) begin
               drop_front(1);
               continue;
            end
            owed_words.push_back(decode_frame());
            taken++;
            drop_front(flen);
         end
         if (taken > 0) begin
            w = owed_words.pop_back();
            w.last_of_run = 1'b1;
            owed_words.push_back(w);
         end
         frames_owed_total += taken;
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("frame %0d %s got %0h, expected %0h",
                                      frames_checked, name, got, want));
      endtask

      // Checks one accepted result word against the oldest owed word.
      task check_result(rsp_word_type got);
         rsp_word_type want;
         if (owed_words.size() == 0) begin
            report_mismatch("result word arrived with no frame owed");
            return;
         end
         want = owed_words.pop_front();
         compare_field("frame_kind", got.frame_kind, want.frame_kind);
         compare_field("command_code", got.command_code, want.command_code);
         compare_field("status_byte", got.status_byte, want.status_byte);
         compare_field("payload_length", got.payload_length, want.payload_length);
         compare_field("pack_voltage", got.pack_voltage, want.pack_voltage);
         compare_field("pack_current", got.pack_current, want.pack_current);
         compare_field("charge_percent", got.charge_percent, want.charge_percent);
         compare_field("voltage_changed", got.voltage_changed, want.voltage_changed);
         compare_field("current_changed", got.current_changed, want.current_changed);
         compare_field("charge_changed", got.charge_changed, want.charge_changed);
         compare_field("any_changed", got.any_changed, want.any_changed);
         compare_field("last_of_run", got.last_of_run, want.last_of_run);
         frames_checked++;
      endtask
   endclass

   frame_scoreboard sb;
   rsp_word_type    seen_word;
   bit              idle_on;
   int              stall_left;
   int              bytes_sent;
   logic [15:0]     last_volt;
   logic [15:0]     last_curr;
   logic [7:0]      last_chg;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: ready drops in short random bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Both handshakes are sampled at the clock edge, before any update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_byte(req_if.rx_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            seen_word.frame_kind      = frame_kind_type'(rsp_if.frame_kind);
            seen_word.command_code    = rsp_if.command_code;
            seen_word.status_byte     = rsp_if.status_byte;
            seen_word.payload_length  = rsp_if.payload_length;
            seen_word.pack_voltage    = rsp_if.pack_voltage;
            seen_word.pack_current    = rsp_if.pack_current;
            seen_word.charge_percent  = rsp_if.charge_percent;
            seen_word.voltage_changed = rsp_if.voltage_changed;
            seen_word.current_changed = rsp_if.current_changed;
            seen_word.charge_changed  = rsp_if.charge_changed;
            seen_word.any_changed     = rsp_if.any_changed;
            seen_word.last_of_run     = rsp_if.last_of_run;
            sb.check_result(seen_word);
         end
      end
   end

   // Offers one byte, with an optional idle burst first, and waits until it is taken.
   task automatic send_byte(input logic [7:0] rx);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= rx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Builds one frame with random payload and checksum and sends its first keep bytes.
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] status,
                             input logic [7:0] len, input logic [15:0] volt,
                             input logic [15:0] curr, input logic [7:0] chg,
                             input bit end_ok, input int keep);
      logic [7:0] frame_bytes[$];
      logic [7:0] bad_end;
      frame_bytes.push_back(START_BYTE);
      frame_bytes.push_back(cmd);
      frame_bytes.push_back(status);
      frame_bytes.push_back(len);
      for (int i = 0; i < int'(len) + 2; i++)
         frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (len >= 4) begin
         frame_bytes[4] = volt[15:8];
         frame_bytes[5] = volt[7:0];
         frame_bytes[6] = curr[15:8];
         frame_bytes[7] = curr[7:0];
      end
      if (len > CHARGE_OFFSET - 4)
         frame_bytes[CHARGE_OFFSET] = chg;
      do bad_end = 8'($urandom_range(0, 255)); while (bad_end == END_BYTE);
      frame_bytes.push_back(end_ok ? END_BYTE : bad_end);
      for (int i = 0; i < frame_bytes.size() && i < keep; i++)
         send_byte(frame_bytes[i]);
   endtask

   // Holds the sender off until every owed frame word has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // An outer candidate of maximum length that fails on its end byte and
   // uncovers 37 minimal frames inside it, all taken out on its last byte.
   task automatic send_nested_run();
      send_byte(START_BYTE);
      send_byte(START_BYTE);
      send_byte(CMD_HWINFO);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(END_BYTE);
      for (int i = 0; i < 36; i++) begin
         send_byte(START_BYTE);
         send_byte(8'($urandom_range(0, 255)));
         send_byte(STATUS_OK);
         send_byte(8'h00);
         send_byte(8'($urandom_range(0, 255)));
         send_byte(8'($urandom_range(0, 255)));
         send_byte(END_BYTE);
      end
      send_byte(8'h00);
      send_byte(8'h00);
   endtask

   // One random well-formed frame of a random kind.
   task automatic send_random_frame();
      logic [7:0]  cmd;
      logic [7:0]  status;
      logic [7:0]  len;
      logic [15:0] volt;
      logic [15:0] curr;
      logic [7:0]  chg;
      volt   = $urandom_range(0, 1) ? last_volt : 16'($urandom_range(0, 65535));
      curr   = $urandom_range(0, 1) ? last_curr : 16'($urandom_range(0, 65535));
      chg    = $urandom_range(0, 1) ? last_chg : 8'($urandom_range(0, 255));
      status = STATUS_OK;
      case ($urandom_range(0, 5))
         0, 1: begin
            cmd = CMD_HWINFO;
            len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(24, 255))
                                               : 8'($urandom_range(23, 30));
            last_volt = volt;
            last_curr = curr;
            last_chg  = chg;
         end
         2: begin
            cmd = CMD_HWINFO;
            len = 8'($urandom_range(0, 22));
         end
         3: begin
            cmd = CMD_CELLINFO;
            len = 8'($urandom_range(0, 24));
         end
         4: begin
            do cmd = 8'($urandom_range(0, 255));
            while (cmd == CMD_HWINFO || cmd == CMD_CELLINFO);
            len = 8'($urandom_range(0, 12));
         end
         default: begin
            cmd    = $urandom_range(0, 1) ? CMD_HWINFO : 8'($urandom_range(0, 255));
            status = 8'($urandom_range(1, 255));
            len    = 8'($urandom_range(0, 30));
         end
      endcase
      send_frame(cmd, status, len, volt, curr, chg, 1'b1, WHOLE_FRAME);
   endtask

   // Run timeout.
   initial begin
      #10_000_000;
      $display("Timeout: frame results still owed or block stalled");
      $display("Verification failed");
      $finish;
   end

   // Main sequence: reset, directed frames, random stream, final drain.
   initial begin
      int rand_start;
      int frames_start;
      int choice;
      sb = new();
      idle_on    = 1'b1;
      bytes_sent = 0;
      last_volt  = '0;
      last_curr  = '0;
      last_chg   = '0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: value extremes, every kind, resync and clearing.
      send_frame(CMD_HWINFO, STATUS_OK, 8'd23, 16'hFFFF, 16'h8000, 8'hFF, 1'b1, WHOLE_FRAME);
      send_frame(CMD_HWINFO, STATUS_OK, 8'd0, 16'h0, 16'h0, 8'h0, 1'b1, WHOLE_FRAME);
      send_frame(CMD_CELLINFO, STATUS_OK, 8'd0, 16'h0, 16'h0, 8'h0, 1'b1, WHOLE_FRAME);
      send_frame(8'h00, STATUS_OK, 8'd0, 16'h0, 16'h0, 8'h0, 1'b1, WHOLE_FRAME);
      send_frame(CMD_HWINFO, 8'hFF, 8'd0, 16'h5555, 16'hAAAA, 8'h42, 1'b1, WHOLE_FRAME);
      // Candidate with a bad end byte, then a good frame behind it.
      send_frame(CMD_CELLINFO, STATUS_OK, 8'd2, 16'h0, 16'h0, 8'h0, 1'b0, WHOLE_FRAME);
      send_frame(8'h10, STATUS_OK, 8'd0, 16'h0, 16'h0, 8'h0, 1'b1, WHOLE_FRAME);
      // Garbage ahead of a frame is dropped; a run without a start byte clears the store.
      send_byte(8'h00);
      send_byte(8'h11);
      send_frame(CMD_CELLINFO, STATUS_OK, 8'd0, 16'h0, 16'h0, 8'h0, 1'b1, WHOLE_FRAME);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(END_BYTE);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h7F);
      drain_results();
      // Longest candidate the length byte allows, hiding the most frames per byte.
      send_nested_run();
      drain_results();

      // Random stream: mostly well-formed frames, some broken ones and noise.
      rand_start   = bytes_sent;
      frames_start = sb.frames_owed_total;
      while (bytes_sent - rand_start < RANDOM_BYTES ||
             sb.frames_owed_total - frames_start < RANDOM_FRAMES) begin
         if (bytes_sent - rand_start >= RANDOM_BYTES * 3 / 4)
            idle_on = 1'b0;
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            send_random_frame();
         end else if (choice < 78) begin
            send_frame(8'($urandom_range(0, 255)), STATUS_OK, 8'($urandom_range(0, 20)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 1'b0, WHOLE_FRAME);
         end else if (choice < 84) begin
            send_frame(8'($urandom_range(0, 255)), STATUS_OK, 8'($urandom_range(0, 20)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 1'b1, $urandom_range(1, 8));
         end else if (choice < 97) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            drain_results();
         end
      end

      // Final drain, then a quiet stretch to catch stray result words.
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d bytes and checked %0d frame words, %0d mismatches.",
               sb.bytes_seen, sb.frames_checked, sb.mismatches);
      $display("Covered every frame kind, value extremes, resync, clearing and a 37-frame run.");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/brd_pkg.sv
rtl/brd_channels.sv
rtl/brd_ram.sv
rtl/bms_response_deframer.sv
bench/bms_response_deframer_tb.sv
